/* rtl/npcs_pkg.sv */
// Package for the nearest palette colour search block.
// Holds sizes, field widths, the sequencer state type and the pipeline tag.
// No dependencies.
package npcs_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int ADDR_W        = $clog2(PALETTE_DEPTH);
  localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
  localparam int CHAN_W        = 8;
  localparam int COLOUR_W      = 3 * CHAN_W;
  localparam int INDEX_W       = 8;
  localparam int USE_W         = 9;
  localparam int SQ_W          = 2 * CHAN_W;
  localparam int DIST_W        = 18;
  localparam int IN_DATA_W     = 48;
  localparam int OUT_DATA_W    = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } npcs_state_t;

  typedef struct packed {
    logic              vld;
    logic [ADDR_W-1:0] pos;
  } npcs_tag_t;

  typedef struct packed {
    npcs_tag_t tag;
    logic      busy;
  } npcs_dist_stat_t;

endpackage

/* rtl/npcs_dist.sv */
// Pipelined distance unit: squared RGB distance of one palette entry per cycle.
// Two register stages (squares, then sum). Depends on npcs_pkg.
module npcs_dist
  import npcs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic [COLOUR_W-1:0] query,
  input  logic [COLOUR_W-1:0] entry,
  input  npcs_tag_t           tag_in,
  output logic [DIST_W-1:0]   dist_sq,
  output npcs_dist_stat_t     stat
);

  logic [CHAN_W-1:0] diff [3];
  logic [SQ_W-1:0]   sq_r [3];
  logic [SQ_W-1:0]   sq_nxt [3];
  npcs_tag_t         tag1_r;
  npcs_tag_t         tag2_r;
  logic [DIST_W-1:0] sum_r;
  logic [DIST_W-1:0] sum_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic [CHAN_W-1:0] q;
      logic [CHAN_W-1:0] e;
      q = query[k*CHAN_W +: CHAN_W];
      e = entry[k*CHAN_W +: CHAN_W];
      diff[k]   = (q > e) ? (q - e) : (e - q);
      sq_nxt[k] = SQ_W'(diff[k]) * SQ_W'(diff[k]);
    end
    sum_nxt = DIST_W'(sq_r[0]) + DIST_W'(sq_r[1]) + DIST_W'(sq_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else begin
      tag1_r <= tag_in;
      tag2_r <= tag1_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) sq_r[k] <= sq_nxt[k];
    sum_r <= sum_nxt;
  end

  assign dist_sq   = sum_r;
  assign stat.tag  = tag2_r;
  assign stat.busy = tag_in.vld | tag1_r.vld | tag2_r.vld;

endmodule

/* rtl/nearest_palette_color_search_unit.sv */
// Top level of the nearest palette colour search block.
// Holds the palette memory, the scan sequencer and the result register.
// Depends on npcs_pkg and npcs_dist.
//
// A load item (tuser 0) writes one palette entry. A query item (tuser 1)
// scans entries 0 to N-1, N being entries_in_use capped at the palette depth,
// one entry per cycle through a single pipelined distance unit, and then
// registers its result; the input is ready only while the block is idle, so
// not during the scan. Ties go to the lowest position. With N zero the result
// carries found, index and distance all zero. Entries must be loaded before a
// query reads them.
module nearest_palette_color_search_unit
  import npcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // entry_index, red, green, blue, entries_in_use
  input  logic                  in_tuser,   // operation
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // best_index, best_distance
  output logic                  out_tuser   // found
);

  logic [INDEX_W-1:0]  in_entry_index;
  logic [COLOUR_W-1:0] in_colour;
  logic [USE_W-1:0]    in_entries_in_use;
  logic                in_accept;

  assign in_entry_index    = in_tdata[INDEX_W-1:0];
  assign in_colour         = {in_tdata[INDEX_W +: CHAN_W],
                              in_tdata[INDEX_W+CHAN_W +: CHAN_W],
                              in_tdata[INDEX_W+2*CHAN_W +: CHAN_W]};
  assign in_entries_in_use = in_tdata[INDEX_W+COLOUR_W +: USE_W];
  assign in_accept         = in_tvalid & in_tready;

  npcs_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    limit_r, limit_nxt;
  logic [COLOUR_W-1:0] query_r, query_nxt;
  logic [DIST_W-1:0]   best_d_r, best_d_nxt;
  logic [ADDR_W-1:0]   best_i_r, best_i_nxt;
  logic                have_r, have_nxt;
  logic                out_vld_r, out_vld_nxt;
  logic                out_found_r;
  logic [INDEX_W-1:0]  out_index_r;
  logic [DIST_W-1:0]   out_dist_r;
  logic                res_load;
  logic                start;

  logic [COLOUR_W-1:0] pal_mem [PALETTE_DEPTH];
  logic [COLOUR_W-1:0] rd_data_r;
  logic [ADDR_W-1:0]   rd_addr;
  logic                wr_en;
  npcs_tag_t           rd_tag, tag1_r;

  logic [DIST_W-1:0]   dist_sq;
  npcs_dist_stat_t     dstat;

  assign wr_en   = in_accept & (in_tuser == 1'b0)
                 & (32'(in_entry_index) < PALETTE_DEPTH);
  assign rd_addr = cnt_r[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) pal_mem[ADDR_W'(in_entry_index)] <= in_colour;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= pal_mem[rd_addr];
  end

  assign rd_tag.vld = (state_r == ST_SCAN) && (cnt_r != limit_r);
  assign rd_tag.pos = rd_addr;

  npcs_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .query   (query_r),
    .entry   (rd_data_r),
    .tag_in  (tag1_r),
    .dist_sq (dist_sq),
    .stat    (dstat)
  );

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    limit_nxt   = limit_r;
    query_nxt   = query_r;
    best_d_nxt  = best_d_r;
    best_i_nxt  = best_i_r;
    have_nxt    = have_r;
    out_vld_nxt = out_vld_r & ~out_tready;
    res_load    = 1'b0;
    in_tready   = (state_r == ST_IDLE);
    start       = in_accept & (in_tuser == 1'b1);

    if (dstat.tag.vld && (!have_r || dist_sq < best_d_r)) begin
      best_d_nxt = dist_sq;
      best_i_nxt = dstat.tag.pos;
      have_nxt   = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt  = ST_SCAN;
          cnt_nxt    = '0;
          limit_nxt  = (32'(in_entries_in_use) > PALETTE_DEPTH)
                     ? CNT_W'(PALETTE_DEPTH) : CNT_W'(in_entries_in_use);
          query_nxt  = in_colour;
          best_d_nxt = '0;
          best_i_nxt = '0;
          have_nxt   = 1'b0;
        end
      end
      ST_SCAN: begin
        if (cnt_r == limit_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!tag1_r.vld && !dstat.busy) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_vld_r || out_tready) begin
          res_load    = 1'b1;
          out_vld_nxt = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
      tag1_r    <= '0;
      cnt_r     <= '0;
      limit_r   <= '0;
      have_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
      tag1_r    <= rd_tag;
      cnt_r     <= cnt_nxt;
      limit_r   <= limit_nxt;
      have_r    <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    query_r  <= query_nxt;
    best_d_r <= best_d_nxt;
    best_i_r <= best_i_nxt;
    if (res_load) begin
      out_found_r <= have_r;
      out_index_r <= INDEX_W'(best_i_r);
      out_dist_r  <= best_d_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {(OUT_DATA_W - INDEX_W - DIST_W)'(0), out_dist_r, out_index_r};

endmodule
